>>> hdl/ptt_pkg.sv
// shared types, codes and constants of the periodic timer table
package ptt_pkg;

	localparam int unsigned MAX_TIMERS_DEF = 16;
	localparam logic [63:0] NEVER = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  timer_id;
		logic [63:0] start_time;
		logic [63:0] period;
		logic [63:0] first_fire;
		logic [63:0] now;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [7:0]  fired_id;
		logic [63:0] elapsed;
		logic        last;
		logic        any_fired;
		logic [63:0] next_fire;
		logic [4:0]  timer_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [63:0] start;
		logic [63:0] period;
		logic [63:0] next;
	} entry_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [63:0] elapsed;
	} fire_rec_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_TICK_RD,
		S_TICK_CHK,
		S_DIV,
		S_MIN_RD,
		S_MIN_CHK,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT
	} state_t;

endpackage

>>> hdl/ptt_div.sv
// restoring divider, one quotient bit per cycle, gives the 64-bit remainder
module ptt_div import ptt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] remainder
);

	logic [63:0] rem_q, dvd_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q, dvd_q[63]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, dsr_q}) : trial[63:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

>>> hdl/ptt_table.sv
// timer entry store: one write port, one registered read port
module ptt_table import ptt_pkg::*; #(
	parameter int unsigned MaxTimers = MAX_TIMERS_DEF,
	localparam int unsigned IW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [MaxTimers];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/periodic_timer_table_top.sv
// periodic timer table: sequencer around the entry store and the divider
// an add or remove walks the table entry by entry; a remove then shifts
// the later entries down. a tick reads and checks each entry and runs the
// divider for each fired timer with a nonzero interval; then come the minimum
// search and the results, one by one. one transaction at a time.
// reset empties the table at once; entry contents stay undefined until added.
module periodic_timer_table_top import ptt_pkg::*; #(
	parameter int unsigned MaxTimers = MAX_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int unsigned IW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
	localparam int unsigned CW = $clog2(MaxTimers + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MaxTimers);

	state_t      state_q, state_d;
	in_item_t    item_q;
	logic [CW-1:0] count_q, ptr_q, nres_q, optr_q;
	logic [1:0]  st_q;
	logic        any_q;
	logic [63:0] best_q;
	entry_t      ent_q;
	out_item_t   out_q;

	logic        t_we, t_re;
	logic [IW-1:0] t_waddr, t_raddr;
	entry_t      t_wdata, t_rdata;

	logic        div_start, div_done;
	logic [63:0] div_rem;

	fire_rec_t   rbuf [MaxTimers];
	fire_rec_t   rb_q;

	logic        at_end, fire, last_res;
	logic [CW-1:0] ptr_nx, total;

	assign at_end = ptr_q == count_q;
	assign ptr_nx = ptr_q + CW'(1);
	assign fire   = item_q.now > t_rdata.next;
	assign total  = (nres_q == '0) ? CW'(1) : nres_q;
	assign last_res = (optr_q + CW'(1)) == total;

	ptt_table #(.MaxTimers(MaxTimers)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	ptt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (t_rdata.next - t_rdata.start),
		.divisor   (t_rdata.period),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		state_d   = state_q;
		t_we      = 1'b0;
		t_re      = 1'b0;
		t_waddr   = ptr_q[IW-1:0];
		t_raddr   = ptr_q[IW-1:0];
		t_wdata   = ent_q;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_data.kind)
						KIND_ADD, KIND_REMOVE: state_d = S_FIND_RD;
						KIND_TICK:             state_d = S_TICK_RD;
						default:               state_d = S_MIN_RD;
					endcase
				end
			end
			S_FIND_RD: begin
				if (at_end) begin
					if (item_q.kind == KIND_ADD && count_q < MAX_CNT) begin
						t_we    = 1'b1;
						t_waddr = count_q[IW-1:0];
						t_wdata = '{id: item_q.timer_id, start: item_q.start_time,
							period: item_q.period, next: item_q.first_fire};
					end
					state_d = S_MIN_RD;
				end else begin
					t_re    = 1'b1;
					state_d = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if (t_rdata.id == item_q.timer_id) begin
					state_d = (item_q.kind == KIND_ADD) ? S_MIN_RD : S_SHIFT_RD;
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_SHIFT_RD: begin
				if (ptr_nx >= count_q) begin
					state_d = S_MIN_RD;
				end else begin
					t_re    = 1'b1;
					t_raddr = ptr_nx[IW-1:0];
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				t_we    = 1'b1;
				t_wdata = t_rdata;
				state_d = S_SHIFT_RD;
			end
			S_TICK_RD: begin
				if (at_end) begin
					state_d = S_MIN_RD;
				end else begin
					t_re    = 1'b1;
					state_d = S_TICK_CHK;
				end
			end
			S_TICK_CHK: begin
				if (fire && t_rdata.period != '0) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					if (fire) begin
						t_we    = 1'b1;
						t_wdata = t_rdata;
						t_wdata.next = NEVER;
					end
					state_d = S_TICK_RD;
				end
			end
			S_DIV: begin
				if (div_done) begin
					// start + ((next-start)/p + 1)*p equals next - rem + p
					t_we    = 1'b1;
					t_wdata.next = ent_q.next - div_rem + ent_q.period;
					state_d = S_TICK_RD;
				end
			end
			S_MIN_RD: begin
				if (at_end) begin
					state_d = S_EMIT_RD;
				end else begin
					t_re    = 1'b1;
					state_d = S_MIN_CHK;
				end
			end
			S_MIN_CHK: state_d = S_MIN_RD;
			S_EMIT_RD: state_d = S_EMIT_LD;
			S_EMIT_LD: state_d = S_EMIT;
			S_EMIT: begin
				if (out_ready) begin
					state_d = last_res ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			nres_q  <= '0;
			optr_q  <= '0;
			any_q   <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					ptr_q  <= '0;
					nres_q <= '0;
					optr_q <= '0;
					any_q  <= 1'b0;
					st_q   <= ST_OK;
				end
				S_FIND_RD: begin
					if (at_end) begin
						ptr_q <= '0;
						if (item_q.kind == KIND_REMOVE) begin
							st_q <= ST_NOT_FOUND;
						end else if (count_q >= MAX_CNT) begin
							st_q <= ST_FULL;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_FIND_CHK: begin
					if (t_rdata.id == item_q.timer_id) begin
						if (item_q.kind == KIND_ADD) begin
							st_q  <= ST_DUPLICATE;
							ptr_q <= '0;
						end
					end else begin
						ptr_q <= ptr_nx;
					end
				end
				S_SHIFT_RD: begin
					if (ptr_nx >= count_q) begin
						count_q <= count_q - CW'(1);
						ptr_q   <= '0;
					end
				end
				S_SHIFT_WR: ptr_q <= ptr_nx;
				S_TICK_RD: begin
					if (at_end) begin
						ptr_q <= '0;
					end
				end
				S_TICK_CHK: begin
					if (fire) begin
						nres_q <= nres_q + CW'(1);
						any_q  <= 1'b1;
					end
					if (!(fire && t_rdata.period != '0)) begin
						ptr_q <= ptr_nx;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ptr_q <= ptr_nx;
					end
				end
				S_MIN_CHK: ptr_q <= ptr_nx;
				S_EMIT: begin
					if (out_ready) begin
						optr_q <= optr_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == S_TICK_CHK) begin
			ent_q <= t_rdata;
			if (fire) begin
				rbuf[nres_q[IW-1:0]] <= '{id: t_rdata.id,
					elapsed: item_q.now - t_rdata.start};
			end
		end
		if (state_q == S_IDLE) begin
			best_q <= NEVER;
		end
		if (state_q == S_MIN_CHK && t_rdata.next < best_q) begin
			best_q <= t_rdata.next;
		end
		if (state_q == S_EMIT_RD) begin
			rb_q <= rbuf[optr_q[IW-1:0]];
		end
		if (state_q == S_EMIT_LD) begin
			out_q.status      <= st_q;
			out_q.fired       <= nres_q != '0;
			out_q.fired_id    <= (nres_q != '0) ? rb_q.id : 8'd0;
			out_q.elapsed     <= (nres_q != '0) ? rb_q.elapsed : 64'd0;
			out_q.last        <= last_res;
			out_q.any_fired   <= any_q;
			out_q.next_fire   <= best_q;
			out_q.timer_count <= 5'(count_q);
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_EMIT;
	assign out_data  = out_q;

endmodule
